/* rtl/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned FieldBits   = 32;
  localparam int unsigned OpBits      = 4;
  localparam int unsigned WideBits    = 64;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [2:0] {
    CLS_INV   = 3'd0,
    CLS_NEG   = 3'd1,
    CLS_FLOOR = 3'd2,
    CLS_CEIL  = 3'd3,
    CLS_ADD   = 3'd4,
    CLS_SUB   = 3'd5,
    CLS_MUL   = 3'd6,
    CLS_DIV   = 3'd7
  } op_cls_e;

  typedef enum logic [1:0] {
    MODE_TRUNC = 2'd0,
    MODE_FLOOR = 2'd1,
    MODE_CEIL  = 2'd2
  } rnd_mode_e;

  // One classified operation handed from front to back.
  typedef struct packed {
    logic [WideBits-1:0] num;
    logic [WideBits-1:0] den;
    logic                divides;
    rnd_mode_e           mode;
  } work_item_t;

endpackage

/* rtl/rau_front.sv */
// Front end: operand capture, products and operation classification.
`timescale 1ns / 1ps

module rau_front #(
  parameter int unsigned WordBits = rau_pkg::WordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic [rau_pkg::OpBits-1:0]     op_i,
  input  logic [rau_pkg::FieldBits-1:0]  a_num_i,
  input  logic [rau_pkg::FieldBits-1:0]  a_den_i,
  input  logic [rau_pkg::FieldBits-1:0]  b_num_i,
  input  logic [rau_pkg::FieldBits-1:0]  b_den_i,
  output logic                           push_o,
  output rau_pkg::work_item_t            item_o
);

  localparam int unsigned Shift = rau_pkg::FieldBits - WordBits;
  localparam int unsigned FB    = rau_pkg::FieldBits;
  localparam int unsigned WB    = rau_pkg::WideBits;

  logic signed [FB-1:0] an, ad, bn, bd;
  logic signed [FB-1:0] an_q, ad_q, bn_q, bd_q;
  logic [rau_pkg::OpBits-1:0] op_q, op2_q;
  logic s1_valid_q, s2_valid_q;
  logic signed [FB-1:0] m0x, m2y;
  logic signed [WB-1:0] m0_d, m1_d, m2_d, m0_q, m1_q, m2_q;
  logic signed [FB-1:0] an2_q, ad2_q;
  rau_pkg::op_cls_e cls1, cls2;

  // Take the low word bits and sign-extend them to the field width.
  assign an = $signed(a_num_i << Shift) >>> Shift;
  assign ad = $signed(a_den_i << Shift) >>> Shift;
  assign bn = $signed(b_num_i << Shift) >>> Shift;
  assign bd = $signed(b_den_i << Shift) >>> Shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      op_q <= op_i;
      an_q <= an;
      ad_q <= ad;
      bn_q <= bn;
      bd_q <= bd;
    end
  end

  assign cls1 = rau_pkg::op_cls_e'(op_q[rau_pkg::OpBits-1:1]);

  always_comb begin
    m0x = (cls1 == rau_pkg::CLS_MUL) ? bn_q : bd_q;
    m2y = (cls1 == rau_pkg::CLS_DIV) ? bn_q : bd_q;
  end

  assign m0_d = an_q * m0x;
  assign m1_d = bn_q * ad_q;
  assign m2_d = ad_q * m2y;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      op2_q <= op_q;
      an2_q <= an_q;
      ad2_q <= ad_q;
      m0_q  <= m0_d;
      m1_q  <= m1_d;
      m2_q  <= m2_d;
    end
  end

  assign cls2 = rau_pkg::op_cls_e'(op2_q[rau_pkg::OpBits-1:1]);

  always_comb begin
    item_o.num     = WB'(an2_q);
    item_o.den     = WB'(ad2_q);
    item_o.divides = op2_q[0];
    item_o.mode    = rau_pkg::MODE_TRUNC;
    case (cls2)
      rau_pkg::CLS_INV: begin
        item_o.num = WB'(ad2_q);
        item_o.den = WB'(an2_q);
      end
      rau_pkg::CLS_NEG: begin
        item_o.num = -WB'(an2_q);
      end
      rau_pkg::CLS_FLOOR: begin
        item_o.divides = 1'b1;
        item_o.mode    = rau_pkg::MODE_FLOOR;
      end
      rau_pkg::CLS_CEIL: begin
        item_o.divides = 1'b1;
        item_o.mode    = rau_pkg::MODE_CEIL;
      end
      rau_pkg::CLS_ADD: begin
        item_o.num = m0_q + m1_q;
        item_o.den = m2_q;
      end
      rau_pkg::CLS_SUB: begin
        item_o.num = m0_q - m1_q;
        item_o.den = m2_q;
      end
      rau_pkg::CLS_MUL, rau_pkg::CLS_DIV: begin
        item_o.num = m0_q;
        item_o.den = m2_q;
      end
      default: begin
        item_o.num = '0;
        item_o.den = '0;
      end
    endcase
  end

  assign push_o = s2_valid_q;

endmodule

/* rtl/rau_queue.sv */
// Short queue between front and back ends.
`timescale 1ns / 1ps

module rau_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rau_pkg::work_item_t item_i,
  input  logic                pop_i,
  output rau_pkg::work_item_t item_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned Depth  = rau_pkg::QueueDepth;
  localparam int unsigned PtrW   = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);

  rau_pkg::work_item_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CountW'(Depth));
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (!full_o || do_pop);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

/* rtl/rau_back.sv */
// Back end: pipelined restoring divider, rounding and result register.
`timescale 1ns / 1ps

module rau_back #(
  parameter int unsigned WordBits = rau_pkg::WordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  rau_pkg::work_item_t           item_i,
  output logic                          valid_o,
  output logic [rau_pkg::FieldBits-1:0] res_num_o,
  output logic [rau_pkg::FieldBits-1:0] res_den_o,
  output logic                          div_zero_o
);

  localparam int unsigned WB    = rau_pkg::WideBits;
  localparam int unsigned FB    = rau_pkg::FieldBits;
  localparam int unsigned Shift = FB - WordBits;

  logic                 vld_q  [WB+1];
  logic [WB-1:0]        rem_q  [WB+1];
  logic [WB-1:0]        qd_q   [WB+1];
  logic [WB-1:0]        dvs_q  [WB+1];
  logic                 sgn_q  [WB+1];
  logic                 dvd_q  [WB+1];
  logic                 zero_q [WB+1];
  rau_pkg::rnd_mode_e   mode_q [WB+1];
  logic [FB-1:0]        nlo_q  [WB+1];
  logic [FB-1:0]        dlo_q  [WB+1];

  logic nneg, dneg;

  assign nneg = item_i.num[WB-1];
  assign dneg = item_i.den[WB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else         vld_q[0] <= load_i;
  end

  // Stage 0 takes magnitudes; the quotient sign rides along.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q[0]  <= '0;
      qd_q[0]   <= nneg ? -item_i.num : item_i.num;
      dvs_q[0]  <= dneg ? -item_i.den : item_i.den;
      sgn_q[0]  <= nneg ^ dneg;
      dvd_q[0]  <= item_i.divides;
      zero_q[0] <= (item_i.den == '0);
      mode_q[0] <= item_i.mode;
      nlo_q[0]  <= item_i.num[FB-1:0];
      dlo_q[0]  <= item_i.den[FB-1:0];
    end
  end

  for (genvar i = 0; i < WB; i++) begin : g_step
    logic [WB:0] trial, diff;
    logic        fits;

    assign trial = {rem_q[i], qd_q[i][WB-1]};
    assign diff  = trial - {1'b0, dvs_q[i]};
    assign fits  = !diff[WB];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i+1] <= 1'b0;
      else         vld_q[i+1] <= vld_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[i]) begin
        rem_q[i+1]  <= fits ? diff[WB-1:0] : trial[WB-1:0];
        qd_q[i+1]   <= {qd_q[i][WB-2:0], fits};
        dvs_q[i+1]  <= dvs_q[i];
        sgn_q[i+1]  <= sgn_q[i];
        dvd_q[i+1]  <= dvd_q[i];
        zero_q[i+1] <= zero_q[i];
        mode_q[i+1] <= mode_q[i];
        nlo_q[i+1]  <= nlo_q[i];
        dlo_q[i+1]  <= dlo_q[i];
      end
    end
  end

  logic [WB-1:0] q_signed, q_round;
  logic          inexact;
  logic [FB-1:0] num_d, den_d, num_q, den_q;
  logic          dz_d, dz_q, valid_q;

  assign inexact  = (rem_q[WB] != '0);
  assign q_signed = sgn_q[WB] ? -qd_q[WB] : qd_q[WB];

  always_comb begin
    q_round = q_signed;
    if (inexact && (mode_q[WB] == rau_pkg::MODE_FLOOR) && sgn_q[WB]) begin
      q_round = q_signed - 1'b1;
    end else if (inexact && (mode_q[WB] == rau_pkg::MODE_CEIL) && !sgn_q[WB]) begin
      q_round = q_signed + 1'b1;
    end
  end

  always_comb begin
    dz_d = 1'b0;
    if (!dvd_q[WB]) begin
      num_d = $signed(nlo_q[WB] << Shift) >>> Shift;
      den_d = $signed(dlo_q[WB] << Shift) >>> Shift;
    end else if (zero_q[WB]) begin
      num_d = '0;
      den_d = '0;
      dz_d  = 1'b1;
    end else begin
      num_d = $signed(q_round[FB-1:0] << Shift) >>> Shift;
      den_d = FB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dz_q    <= 1'b0;
    end else begin
      valid_q <= vld_q[WB];
      dz_q    <= vld_q[WB] && dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[WB]) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  assign valid_o    = valid_q;
  assign res_num_o  = num_q;
  assign res_den_o  = den_q;
  assign div_zero_o = dz_q;

endmodule

/* rtl/rational_arithmetic_unit_top.sv */
// Top level of the rational arithmetic unit.
`timescale 1ns / 1ps

// Rational arithmetic unit: one operation (invert, negate, floor, ceil, add,
// subtract, multiply, divide, all but floor and ceil with a truncating variant)
// per start beat. A new beat can be taken every cycle; busy only rises if
// the internal queue fills, which does not happen since the back end drains
// it each cycle. Each result appears on res_*_o with valid_o high for exactly
// one cycle, in order, after operand capture at the accepting edge, the 32x32
// product stage, one queue stage, the divider input stage, the 64 steps of
// the pipelined restoring divider and the result register. Results cannot be
// held off by the receiver.
module rational_arithmetic_unit_top #(
  parameter int unsigned WordBits = rau_pkg::WordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [rau_pkg::OpBits-1:0]    op_i,
  input  logic [rau_pkg::FieldBits-1:0] a_num_i,
  input  logic [rau_pkg::FieldBits-1:0] a_den_i,
  input  logic [rau_pkg::FieldBits-1:0] b_num_i,
  input  logic [rau_pkg::FieldBits-1:0] b_den_i,
  output logic                          valid_o,
  output logic [rau_pkg::FieldBits-1:0] res_num_o,
  output logic [rau_pkg::FieldBits-1:0] res_den_o,
  output logic                          div_zero_o
);

  logic                take;
  logic                push, q_empty, q_full;
  rau_pkg::work_item_t front_item, head_item;

  assign busy = q_full;
  assign take = start && !busy;

  rau_front #(.WordBits(WordBits)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .op_i    (op_i),
    .a_num_i (a_num_i),
    .a_den_i (a_den_i),
    .b_num_i (b_num_i),
    .b_den_i (b_den_i),
    .push_o  (push),
    .item_o  (front_item)
  );

  rau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (!q_empty),
    .item_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  rau_back #(.WordBits(WordBits)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (!q_empty),
    .item_i     (head_item),
    .valid_o    (valid_o),
    .res_num_o  (res_num_o),
    .res_den_o  (res_den_o),
    .div_zero_o (div_zero_o)
  );

  a_dz_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_zero_o |-> valid_o) else $error("div_zero without result strobe");

  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_zero_o |-> (res_num_o == '0) && (res_den_o == '0))
    else $error("zero divisor result not cleared");

  a_queue_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_full) else $error("front/back queue filled");

endmodule
